// ===== hw/rtl/hann_windowed_stft_unit_macros.svh =====
// Assertion macros for the Hann-windowed STFT unit.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef HANN_WINDOWED_STFT_UNIT_MACROS_SVH
`define HANN_WINDOWED_STFT_UNIT_MACROS_SVH

// Same-cycle implication.
`define HWS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hws: same-cycle check failed");

// Next-cycle implication.
`define HWS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hws: next-cycle check failed");

`endif

// ===== hw/rtl/hws_pkg.sv =====
// Shared types, constants and table builders of the Hann-windowed STFT unit.
// No dependencies; the front end, back end and top level import this package.
`timescale 1ns / 1ps
package hws_pkg;

    localparam int WINDOW_DEF = 64;
    localparam int MAX_WINDOW = 64;
    localparam int SAMPLE_W   = 16;
    localparam int HOP_W      = 7;
    localparam int IDX_W      = 6;
    localparam int BIN_W      = 23;
    localparam int HANN_W     = 17;
    localparam int XW_W       = 32;
    localparam int TW_W       = 26;
    localparam int PROD_W     = XW_W + TW_W;
    localparam int ACC_W      = 62;
    localparam int ROUND_SH   = 39;
    localparam int CMD_DEPTH  = 2;
    localparam int OUT_DEPTH  = 2;
    localparam int START_W    = 6;
    localparam int COUNT_W    = 7;

    localparam logic [HOP_W-1:0] HOP_RESET = 7'd16;
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          Q30_ONE     = 64'sd1073741824;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_MAC,
        B_DRAIN,
        B_ROUND
    } back_state_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
        logic               is_final;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic signed [BIN_W-1:0] re;
        logic signed [BIN_W-1:0] im;
        logic                    frame_last;
        logic                    stream_last;
    } bin_t;

    typedef logic [MAX_WINDOW-1:0][HANN_W-1:0] hann_tab_t;
    typedef logic [MAX_WINDOW-1:0][TW_W-1:0]   tw_tab_t;

    // Shift-subtract quotient, elaboration only.
    function automatic longint unsigned ce_udiv(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // cos(pi/2 * a / q) in Q30 by quadrant reduction and a Taylor series.
    function automatic longint cos_quarter(longint unsigned a, longint unsigned q);
        longint unsigned quo;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned ct;
        longint unsigned st;
        longint unsigned dc;
        longint unsigned ds;
        longint c;
        longint s;
        longint res;
        quo  = ce_udiv(a, q);
        quad = quo & 64'd3;
        rem  = a - quo * q;
        x    = ce_udiv(rem * HALF_PI_Q30 + (q >> 1), q);
        x2   = (x * x + (64'd1 << 29)) >> 30;
        c    = Q30_ONE;
        s    = longint'(x);
        ct   = 64'd1 << 30;
        st   = x;
        for (int k = 1; k <= 7; k++)
        begin
            dc = longint'(unsigned'((2 * k - 1) * (2 * k)));
            ds = longint'(unsigned'((2 * k) * (2 * k + 1)));
            ct = ce_udiv(((ct * x2 + (64'd1 << 29)) >> 30) + (dc >> 1), dc);
            st = ce_udiv(((st * x2 + (64'd1 << 29)) >> 30) + (ds >> 1), ds);
            if (k % 2 == 1)
            begin
                c = c - longint'(ct);
                s = s - longint'(st);
            end
            else
            begin
                c = c + longint'(ct);
                s = s + longint'(st);
            end
        end
        case (quad)
            64'd0:   res = c;
            64'd1:   res = -s;
            64'd2:   res = -c;
            default: res = s;
        endcase
        return res;
    endfunction

    // Round half up from Q30 to Q24.
    function automatic longint round_q24(longint v);
        return (v + 64'sd32) >>> 6;
    endfunction

    function automatic hann_tab_t build_hann(int w);
        hann_tab_t t;
        longint    c;
        longint    h;
        int        p;
        t = '0;
        for (int n = 0; n < MAX_WINDOW; n++)
        begin
            if (n < w)
            begin
                p = (n == w - 1) ? 0 : n;
                c = cos_quarter(longint'(unsigned'(4 * p)), longint'(unsigned'(w - 1)));
                if (c > Q30_ONE)
                    c = Q30_ONE;
                if (c < -Q30_ONE)
                    c = -Q30_ONE;
                h = (Q30_ONE - c + 64'sd32768) >>> 16;
                t[n] = h[HANN_W-1:0];
            end
        end
        return t;
    endfunction

    function automatic tw_tab_t build_cos(int w);
        tw_tab_t t;
        longint  v;
        t = '0;
        for (int n = 0; n < MAX_WINDOW; n++)
        begin
            if (n < w)
            begin
                v = round_q24(cos_quarter(longint'(unsigned'(4 * n)), longint'(unsigned'(w))));
                t[n] = v[TW_W-1:0];
            end
        end
        return t;
    endfunction

    function automatic tw_tab_t build_sin(int w);
        tw_tab_t t;
        longint  v;
        int      a;
        t = '0;
        for (int n = 0; n < MAX_WINDOW; n++)
        begin
            if (n < w)
            begin
                a = 4 * n + 3 * w;
                if (a >= 4 * w)
                    a = a - 4 * w;
                v = round_q24(cos_quarter(longint'(unsigned'(a)), longint'(unsigned'(w))));
                t[n] = v[TW_W-1:0];
            end
        end
        return t;
    endfunction

endpackage

// ===== hw/rtl/hws_fifo.sv =====
// Small register queue used for frame commands and finished bins.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module hws_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hw/rtl/hws_front.sv =====
// Front end: hop register, sample ring, frame detection and command issue.
// Depends on hws_pkg.
`timescale 1ns / 1ps
module hws_front import hws_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       mode,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [HOP_W-1:0]           cfg_hop_step,
    input  logic                       back_loading,
    input  logic                       cmd_empty,
    output logic                       cmd_push,
    output cmd_t                       cmd_data,
    input  logic [$clog2(WINDOW)-1:0]  rd_addr,
    output logic [SAMPLE_W-1:0]        rd_data
);
    localparam int PW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);

    logic [SAMPLE_W-1:0] ring_mem [WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [HOP_W-1:0]    hop_reg;
    logic [PW-1:0]       wp_reg;
    logic [PW-1:0]       wp_next;
    logic [CW-1:0]       pend_reg;
    logic [CW-1:0]       pend_next;
    logic [CW-1:0]       hop_eff;
    logic [PW-1:0]       wp_inc;
    logic [CW-1:0]       pend_inc;
    logic [PW:0]         flush_sum;
    logic [PW-1:0]       flush_start;
    logic                accept;
    logic                ring_we;

    assign cfg_ready = 1'b1;
    assign full      = !cmd_empty || back_loading;
    assign accept    = push && !full;
    assign ring_we   = accept && (mode == MODE_SAMPLE);
    assign rd_data   = rd_data_reg;

    // clamp the hop into 1..WINDOW
    always_comb
    begin
        if (hop_reg == '0)
            hop_eff = CW'(1);
        else if (hop_reg > HOP_W'(WINDOW))
            hop_eff = CW'(WINDOW);
        else
            hop_eff = CW'(hop_reg);
    end

    assign wp_inc      = (wp_reg == PW'(WINDOW - 1)) ? '0 : wp_reg + 1'b1;
    assign pend_inc    = pend_reg + 1'b1;
    assign flush_sum   = {1'b0, wp_reg} + (PW+1)'(WINDOW) - (PW+1)'(pend_reg);
    assign flush_start = (flush_sum >= (PW+1)'(WINDOW)) ? PW'(flush_sum - (PW+1)'(WINDOW))
                                                        : PW'(flush_sum);

    always_comb
    begin
        wp_next           = wp_reg;
        pend_next         = pend_reg;
        cmd_push          = 1'b0;
        cmd_data.start    = START_W'(wp_inc);
        cmd_data.count    = COUNT_W'(WINDOW);
        cmd_data.is_final = 1'b0;
        if (accept)
        begin
            if (mode == MODE_FLUSH)
            begin
                cmd_push          = 1'b1;
                cmd_data.start    = START_W'(flush_start);
                cmd_data.count    = COUNT_W'(pend_reg);
                cmd_data.is_final = 1'b1;
                wp_next           = '0;
                pend_next         = '0;
            end
            else
            begin
                wp_next = wp_inc;
                if (pend_inc == CW'(WINDOW))
                begin
                    cmd_push  = 1'b1;
                    pend_next = CW'(WINDOW) - hop_eff;
                end
                else
                begin
                    pend_next = pend_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_reg  <= HOP_RESET;
            wp_reg   <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                hop_reg <= cfg_hop_step;
            wp_reg   <= wp_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[wp_reg] <= sample;
        rd_data_reg <= ring_mem[rd_addr];
    end

endmodule

// ===== hw/rtl/hws_back.sv =====
// Back end: windowing pass into a frame buffer, then one multiply-accumulate
// pass per bin with rounding and saturation. Depends on hws_pkg.
`timescale 1ns / 1ps
module hws_back import hws_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_empty,
    input  cmd_t                      cmd_data,
    output logic                      cmd_pop,
    output logic [$clog2(WINDOW)-1:0] rd_addr,
    input  logic [SAMPLE_W-1:0]       rd_data,
    output logic                      loading,
    input  logic                      out_full,
    output logic                      out_push,
    output bin_t                      out_data
);
    localparam int PW   = $clog2(WINDOW);
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int KW   = $clog2(WINDOW / 2 + 1);
    localparam int SH_W = ACC_W + 1 - ROUND_SH;

    localparam hann_tab_t HANN_TAB = build_hann(WINDOW);
    localparam tw_tab_t   COS_TAB  = build_cos(WINDOW);
    localparam tw_tab_t   SIN_TAB  = build_sin(WINDOW);

    back_state_t state_reg;
    back_state_t state_next;

    logic [CW-1:0] count_reg;
    logic          final_reg;

    logic [CW-1:0]             ld_n_reg;
    logic [PW-1:0]             ld_addr_reg;
    logic                      ld_v_reg;
    logic [PW-1:0]             ld_nd_reg;
    logic                      ld_keep_reg;
    logic signed [HANN_W-1:0]  hann_reg;
    logic signed [XW_W-1:0]    xw_mem [WINDOW];
    logic signed [SAMPLE_W+HANN_W-1:0] xw_full;

    logic [PW-1:0]             mac_n_reg;
    logic [PW-1:0]             tw_idx_reg;
    logic [PW:0]               tw_sum;
    logic [KW-1:0]             k_reg;
    logic signed [XW_W-1:0]    xw_rd_reg;
    logic signed [TW_W-1:0]    cos_rd_reg;
    logic signed [TW_W-1:0]    sin_rd_reg;
    logic                      v1_reg;
    logic signed [PROD_W-1:0]  prod_re_reg;
    logic signed [PROD_W-1:0]  prod_im_reg;
    logic                      v2_reg;
    logic signed [ACC_W-1:0]   acc_re_reg;
    logic signed [ACC_W-1:0]   acc_im_reg;

    logic signed [ACC_W:0]     rnd_re;
    logic signed [ACC_W:0]     rnd_im;
    logic signed [SH_W-1:0]    sh_re;
    logic signed [SH_W-1:0]    sh_im;
    logic signed [SH_W-1:0]    sat_re;
    logic signed [SH_W-1:0]    sat_im;

    logic ld_issue;
    logic mac_issue;
    logic last_bin;

    function automatic logic signed [SH_W-1:0] sat_bin(logic signed [SH_W-1:0] v);
        logic signed [SH_W-1:0] lim;
        lim = SH_W'(2097152);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    assign loading   = (state_reg == B_LOAD);
    assign rd_addr   = ld_addr_reg;
    assign ld_issue  = (state_reg == B_LOAD) && (ld_n_reg != CW'(WINDOW));
    assign mac_issue = (state_reg == B_MAC);
    assign last_bin  = (k_reg == KW'(WINDOW / 2));
    assign tw_sum    = {1'b0, tw_idx_reg} + (PW+1)'(k_reg);
    assign xw_full   = $signed(rd_data) * hann_reg;

    assign rnd_re = (ACC_W+1)'(acc_re_reg) + ((ACC_W+1)'(1) <<< (ROUND_SH - 1));
    assign rnd_im = (ACC_W+1)'(acc_im_reg) + ((ACC_W+1)'(1) <<< (ROUND_SH - 1));
    assign sh_re  = SH_W'(rnd_re >>> ROUND_SH);
    assign sh_im  = SH_W'(rnd_im >>> ROUND_SH);
    assign sat_re = sat_bin(sh_re);
    assign sat_im = sat_bin(sh_im);

    assign out_data.index       = IDX_W'(k_reg);
    assign out_data.re          = BIN_W'(sat_re);
    assign out_data.im          = BIN_W'(sat_im);
    assign out_data.frame_last  = last_bin;
    assign out_data.stream_last = final_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        out_push   = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    state_next = B_LOAD;
                end
            end
            B_LOAD:
            begin
                if (ld_n_reg == CW'(WINDOW) && !ld_v_reg)
                    state_next = B_MAC;
            end
            B_MAC:
            begin
                if (mac_n_reg == PW'(WINDOW - 1))
                    state_next = B_DRAIN;
            end
            B_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = B_ROUND;
            end
            B_ROUND:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = last_bin ? B_IDLE : B_MAC;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    // control counters and valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_n_reg    <= '0;
            ld_addr_reg <= '0;
            ld_v_reg    <= 1'b0;
            mac_n_reg   <= '0;
            tw_idx_reg  <= '0;
            k_reg       <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            count_reg   <= '0;
            final_reg   <= 1'b0;
        end
        else
        begin
            v1_reg   <= mac_issue;
            v2_reg   <= v1_reg;
            ld_v_reg <= ld_issue;
            if (cmd_pop)
            begin
                count_reg   <= CW'(cmd_data.count);
                final_reg   <= cmd_data.is_final;
                ld_n_reg    <= '0;
                ld_addr_reg <= PW'(cmd_data.start);
                mac_n_reg   <= '0;
                tw_idx_reg  <= '0;
                k_reg       <= '0;
            end
            if (ld_issue)
            begin
                ld_n_reg    <= ld_n_reg + 1'b1;
                ld_addr_reg <= (ld_addr_reg == PW'(WINDOW - 1)) ? '0 : ld_addr_reg + 1'b1;
            end
            if (mac_issue)
            begin
                mac_n_reg  <= mac_n_reg + 1'b1;
                tw_idx_reg <= (tw_sum >= (PW+1)'(WINDOW)) ? PW'(tw_sum - (PW+1)'(WINDOW))
                                                          : PW'(tw_sum);
            end
            if (out_push)
            begin
                k_reg      <= k_reg + 1'b1;
                mac_n_reg  <= '0;
                tw_idx_reg <= '0;
            end
        end
    end

    // datapath: window multiply, twiddle multiply, accumulate
    always_ff @(posedge clk)
    begin
        if (ld_issue)
        begin
            ld_nd_reg   <= PW'(ld_n_reg);
            ld_keep_reg <= (ld_n_reg < count_reg);
            hann_reg    <= $signed(HANN_TAB[PW'(ld_n_reg)]);
        end
        if (ld_v_reg)
            xw_mem[ld_nd_reg] <= ld_keep_reg ? XW_W'(xw_full) : '0;
        if (mac_issue)
        begin
            xw_rd_reg  <= xw_mem[mac_n_reg];
            cos_rd_reg <= $signed(COS_TAB[tw_idx_reg]);
            sin_rd_reg <= $signed(SIN_TAB[tw_idx_reg]);
        end
        prod_re_reg <= xw_rd_reg * cos_rd_reg;
        prod_im_reg <= xw_rd_reg * sin_rd_reg;
        if (cmd_pop || out_push)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(prod_re_reg);
            acc_im_reg <= acc_im_reg - ACC_W'(prod_im_reg);
        end
    end

endmodule

// ===== hw/rtl/hann_windowed_stft_unit.sv =====
// Hann-windowed STFT unit, top level: front end, command queue, back end
// and result queue. Depends on hws_pkg, hws_front, hws_back, hws_fifo and
// the macro header hann_windowed_stft_unit_macros.svh.
//
// Usage:
//  - Input queue: drive mode/sample and raise push; the transaction happens
//    on a rising edge with push high and full low. mode 0 stores a sample,
//    mode 1 ends the stream and flushes a zero-padded frame.
//  - Result queue: while empty is low the oldest bin sits on bin_index,
//    bin_real, bin_imag, frame_last, stream_last; raise pop to take it.
//  - Config: cfg_hop_step is written when cfg_valid and cfg_ready are high;
//    cfg_ready is always high. Write only while the block is idle.
//  - Samples that do not finish a frame are taken back to back while full
//    is low. A frame is windowed with one ring read per sample, then its
//    WINDOW/2+1 bins are computed one at a time on the multiply-accumulate
//    unit. full stays high while a frame command waits and during the
//    windowing pass; samples are taken again while the bins are computed.
//  - When the result receiver stalls, the back end holds at the finished
//    bin; nothing is dropped.
//  - Reset clears pointers, counts, queues and sets the hop to 16; the
//    sample ring is not cleared.
`timescale 1ns / 1ps
`include "hann_windowed_stft_unit_macros.svh"
module hann_windowed_stft_unit import hws_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       mode,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       empty,
    input  logic                       pop,
    output logic [IDX_W-1:0]           bin_index,
    output logic signed [BIN_W-1:0]    bin_real,
    output logic signed [BIN_W-1:0]    bin_imag,
    output logic                       frame_last,
    output logic                       stream_last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [HOP_W-1:0]           cfg_hop_step
);
    localparam int PW = $clog2(WINDOW);

    // front to back: command queue and ring read port
    logic          cmd_push;
    logic          cmd_pop;
    logic          cmd_empty;
    logic          cmd_full;
    cmd_t          cmd_in;
    cmd_t          cmd_out;
    logic [PW-1:0] rd_addr;
    logic [SAMPLE_W-1:0] rd_data;
    logic          back_loading;

    // back to result queue
    logic out_push;
    logic out_full;
    bin_t out_in;
    bin_t out_head;

    hws_front #(
        .WINDOW(WINDOW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .sample       (sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_hop_step (cfg_hop_step),
        .back_loading (back_loading),
        .cmd_empty    (cmd_empty),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_in),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    // Hold frame commands between the front and back ends.
    hws_fifo #(
        .WIDTH($bits(cmd_t)),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    hws_back #(
        .WINDOW(WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .loading   (back_loading),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (out_in)
    );

    // Decouple finished bins from the receiver.
    hws_fifo #(
        .WIDTH($bits(bin_t)),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_in),
        .rd_en   (pop),
        .rd_data (out_head),
        .full    (out_full),
        .empty   (empty)
    );

    assign bin_index   = out_head.index;
    assign bin_real    = out_head.re;
    assign bin_imag    = out_head.im;
    assign frame_last  = out_head.frame_last;
    assign stream_last = out_head.stream_last;

    // The back end never pushes into a full result queue.
    `HWS_ASSERT_IMP(a_out_no_overflow, out_push, !out_full)
    // The command queue never holds more than one frame.
    `HWS_ASSERT_IMP(a_cmd_single, cmd_push, cmd_empty && !cmd_full)
    // A flush transaction locks the input until its frame is windowed.
    `HWS_ASSERT_NXT(a_flush_locks, push && !full && mode == MODE_FLUSH, full)
    // The last bin of each frame carries the top bin number.
    `HWS_ASSERT_IMP(a_frame_last_idx, !empty && frame_last, bin_index == IDX_W'(WINDOW / 2))

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for hann_windowed_stft_unit: streams audio samples
// and end-of-stream flushes, predicts every windowed DFT bin, checks each result.
// Depends on hws_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb_top import hws_pkg::*;;

    localparam int WIN      = 64;
    localparam int NUM_BINS = WIN / 2 + 1;
    // Upper bound on the cycles a frame keeps the unit busy after the last bin.
    localparam int SETTLE_CYCLES = 2600;

    typedef struct {
        logic [IDX_W-1:0]        index;
        logic signed [BIN_W-1:0] re;
        logic signed [BIN_W-1:0] im;
        logic                    frame_last;
        logic                    stream_last;
    } spectrum_bin_t;

    // Spectrum predictor plus the queue of bins still owed by the unit.
    class stft_scoreboard;
        longint        hann_w[WIN];
        longint        cos_tw[WIN];
        longint        sin_tw[WIN];
        int            samples[WIN];
        int unsigned   wr_ptr;
        int unsigned   fill;
        int unsigned   hop;
        spectrum_bin_t owed_bins[$];
        int            mismatches;

        function new();
            longint c;
            for (int n = 0; n < WIN; n++)
            begin
                c = cos_q30(4 * (n % (WIN - 1)), WIN - 1);
                if (c > 64'sd1073741824)
                    c = 64'sd1073741824;
                if (c < -64'sd1073741824)
                    c = -64'sd1073741824;
                hann_w[n] = (64'sd1073741824 - c + 64'sd32768) >>> 16;
                cos_tw[n] = (cos_q30(4 * n, WIN) + 64'sd32) >>> 6;
                sin_tw[n] = (cos_q30((4 * n + 3 * WIN) % (4 * WIN), WIN) + 64'sd32) >>> 6;
                samples[n] = 0;
            end
            wr_ptr     = 0;
            fill       = 0;
            hop        = 16;
            mismatches = 0;
        endfunction

        // cos(pi/2 * a / q) in Q30: quadrant reduction, then a rounded Taylor series.
        function longint cos_q30(int unsigned a, int unsigned q);
            longint unsigned quad, rem, x, x2, ct, st, dc, ds;
            longint          c, s;
            quad = (a / q) & 3;
            rem  = a % q;
            x    = (rem * 64'd1686629713 + q / 2) / q;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            c    = 64'sd1073741824;
            s    = longint'(x);
            ct   = 64'd1 << 30;
            st   = x;
            for (int k = 1; k <= 7; k++)
            begin
                dc = (2 * k - 1) * (2 * k);
                ds = (2 * k) * (2 * k + 1);
                ct = (((ct * x2 + (64'd1 << 29)) >> 30) + dc / 2) / dc;
                st = (((st * x2 + (64'd1 << 29)) >> 30) + ds / 2) / ds;
                if (k % 2 == 1)
                begin
                    c -= longint'(ct);
                    s -= longint'(st);
                end
                else
                begin
                    c += longint'(ct);
                    s += longint'(st);
                end
            end
            case (quad)
                0:       return c;
                1:       return -s;
                2:       return -c;
                default: return s;
            endcase
        endfunction

        function longint round_bin(longint acc);
            longint v;
            v = (acc + (64'sd1 << 38)) >>> 39;
            if (v > 2097152)
                v = 2097152;
            if (v < -2097152)
                v = -2097152;
            return v;
        endfunction

        // Window the newest 'count' samples (zero-padded) and queue all bins.
        function void queue_spectrum(int unsigned count, bit is_final);
            longint        xw[WIN];
            longint        re, im;
            int unsigned   first;
            spectrum_bin_t b;
            first = (wr_ptr + WIN - count) % WIN;
            for (int n = 0; n < WIN; n++)
                xw[n] = (n < count) ? longint'(samples[(first + n) % WIN]) * hann_w[n] : 0;
            for (int k = 0; k < NUM_BINS; k++)
            begin
                re = 0;
                im = 0;
                for (int n = 0; n < WIN; n++)
                begin
                    re += xw[n] * cos_tw[(k * n) % WIN];
                    im -= xw[n] * sin_tw[(k * n) % WIN];
                end
                b.index       = IDX_W'(k);
                b.re          = BIN_W'(round_bin(re));
                b.im          = BIN_W'(round_bin(im));
                b.frame_last  = (k == NUM_BINS - 1);
                b.stream_last = is_final;
                owed_bins.push_back(b);
            end
        endfunction

        function void set_hop(logic [HOP_W-1:0] v);
            hop = 32'(v);
        endfunction

        function void note_input(logic m, logic signed [SAMPLE_W-1:0] smp);
            int unsigned h;
            h = (hop < 1) ? 1 : (hop > WIN) ? WIN : hop;
            if (m == MODE_FLUSH)
            begin
                queue_spectrum((fill < WIN) ? fill : WIN, 1'b1);
                wr_ptr = 0;
                fill   = 0;
                return;
            end
            samples[wr_ptr] = int'(smp);
            wr_ptr = (wr_ptr + 1) % WIN;
            fill++;
            if (fill >= WIN)
            begin
                queue_spectrum(WIN, 1'b0);
                fill = WIN - h;
            end
        endfunction

        function void check_result(spectrum_bin_t got);
            spectrum_bin_t want;
            if (owed_bins.size() == 0)
            begin
                $error("unexpected bin %0d with nothing owed", got.index);
                mismatches++;
                return;
            end
            want = owed_bins.pop_front();
            if (got.index !== want.index)
            begin
                $error("bin_index expected %0d got %0d", want.index, got.index);
                mismatches++;
            end
            if (got.re !== want.re)
            begin
                $error("bin_real expected %0d got %0d", want.re, got.re);
                mismatches++;
            end
            if (got.im !== want.im)
            begin
                $error("bin_imag expected %0d got %0d", want.im, got.im);
                mismatches++;
            end
            if (got.frame_last !== want.frame_last)
            begin
                $error("frame_last expected %0b got %0b", want.frame_last, got.frame_last);
                mismatches++;
            end
            if (got.stream_last !== want.stream_last)
            begin
                $error("stream_last expected %0b got %0b", want.stream_last, got.stream_last);
                mismatches++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       empty;
    logic                       pop;
    logic [IDX_W-1:0]           bin_index;
    logic signed [BIN_W-1:0]    bin_real;
    logic signed [BIN_W-1:0]    bin_imag;
    logic                       frame_last;
    logic                       stream_last;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [HOP_W-1:0]           cfg_hop_step;

    stft_scoreboard sb;
    bit             tx_burst;   // sender runs back to back while set
    bit             rx_burst;   // receiver pops every cycle while set
    int             rx_wait;

    hann_windowed_stft_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .sample       (sample),
        .empty        (empty),
        .pop          (pop),
        .bin_index    (bin_index),
        .bin_real     (bin_real),
        .bin_imag     (bin_imag),
        .frame_last   (frame_last),
        .stream_last  (stream_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_hop_step (cfg_hop_step)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the unit hangs.
    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: take a transaction whenever pop and !empty meet at an edge,
    // then hold pop low for a random number of cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                sb.check_result('{bin_index, bin_real, bin_imag, frame_last, stream_last});
                if ($urandom_range(0, 39) == 0)
                    rx_burst = ~rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 16);
                if (rx_wait > 0)
                    pop <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                if (rx_wait == 0)
                    pop <= 1'b1;
            end
        end
    end

    // Present one input transaction and hold it until accepted. push is left
    // high so a back-to-back item needs no drop in between.
    task automatic send_item(logic m, logic signed [SAMPLE_W-1:0] smp);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        mode   <= m;
        sample <= smp;
        do
            @(posedge clk);
        while (full);
        sb.note_input(m, smp);
    endtask

    // Drop push, wait for every owed bin, then let the back end settle.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.owed_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_hop(logic [HOP_W-1:0] v);
        cfg_valid    <= 1'b1;
        cfg_hop_step <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_hop(v);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // One stream at a given hop: random samples, then an end-of-stream flush.
    task automatic run_stream(logic [HOP_W-1:0] h, int n_samples);
        write_hop(h);
        tx_burst = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < n_samples; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                tx_burst = ~tx_burst;
            send_item(MODE_SAMPLE, pick_sample());
        end
        send_item(MODE_FLUSH, SAMPLE_W'($urandom));
        drain();
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        push         = 1'b0;
        mode         = MODE_SAMPLE;
        sample       = '0;
        pop          = 1'b1;
        cfg_valid    = 1'b0;
        cfg_hop_step = HOP_RESET;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;
        rx_wait      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Flush with nothing pending: an all-zero final frame.
        send_item(MODE_FLUSH, 16'sh7FFF);
        drain();

        // Hop beyond the window clamps to the window; short padded stream
        // with full-scale samples of both signs.
        write_hop(7'd127);
        send_item(MODE_SAMPLE, 16'sh7FFF);
        send_item(MODE_SAMPLE, 16'sh8000);
        send_item(MODE_SAMPLE, 16'sh0000);
        send_item(MODE_SAMPLE, 16'shFFFF);
        send_item(MODE_FLUSH, 16'sh0000);
        drain();

        // Hop of one emits a frame per sample once the window is full;
        // hop of zero must act the same.
        run_stream(7'd1, 70);
        run_stream(7'd0, 68);
        run_stream(7'd64, 20);
        run_stream(7'd16, 8);
        run_stream(7'($urandom_range(2, 63)), 10);

        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
